>>> rtl/core/pofs_pkg.sv
// Shared types, codes and the divide-by-three digit step for the path outline block.
package pofs_pkg;

  // Path command codes; codes above finish are ignored
  typedef enum logic [2:0] {
    CMD_MOVE   = 3'd0,
    CMD_LINE   = 3'd1,
    CMD_QUAD   = 3'd2,
    CMD_CUBIC  = 3'd3,
    CMD_FINISH = 3'd4
  } cmd_t;

  // Tag record codes
  typedef enum logic [1:0] {
    TAG_BEGIN  = 2'd0,
    TAG_END    = 2'd1,
    TAG_LINE   = 2'd2,
    TAG_BEZIER = 2'd3
  } tag_t;

  // Record kinds
  localparam logic REC_TAG   = 1'b0;
  localparam logic REC_POINT = 1'b1;

  // Long division by three runs one byte digit per pipeline stage
  localparam int DIGIT_W = 8;

  // 683 / 2048 approximates 1/3 closely enough for any value below 768
  localparam logic [19:0] RECIP3 = 20'd683;

  // Record plan of one queued item: optional begin, 0..3 points, optional tag
  typedef struct packed {
    logic       has_begin;
    logic [1:0] npts;
    logic       has_tag;
    tag_t       tag;
  } rec_ctl_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] q;
    logic [1:0]         r;
  } div3_digit_t;

  // One digit of long division by three: (rem * 256 + digit) / 3, remainder kept
  function automatic div3_digit_t div3_digit(input logic [1:0] rem_in,
                                             input logic [DIGIT_W-1:0] digit);
    logic [9:0]  v;
    logic [19:0] prod;
    logic [9:0]  three_q;
    div3_digit_t res;
    v       = {rem_in, digit};
    prod    = 20'(v) * RECIP3;
    res.q   = prod[18:11];
    three_q = {2'b00, res.q} + {1'b0, res.q, 1'b0};
    res.r   = 2'(v - three_q);
    return res;
  endfunction

endpackage

>>> rtl/core/pofs_fifo.sv
// Small register queue between the command front end and the record sequencer.
module pofs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             nempty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign nempty  = (count_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && nempty;
  assign rdata   = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

>>> rtl/core/pofs_front.sv
// Command front end: pen state, item classification and the quadratic-to-cubic pipeline.
module pofs_front import pofs_pkg::*; #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_cmd,
  input  logic [W-1:0]        in_to_x,
  input  logic [W-1:0]        in_to_y,
  input  logic [W-1:0]        in_ctrl1_x,
  input  logic [W-1:0]        in_ctrl1_y,
  input  logic [W-1:0]        in_ctrl2_x,
  input  logic [W-1:0]        in_ctrl2_y,
  input  logic                q_full,
  output logic                q_push,
  output rec_ctl_t            q_ctl,
  output logic [3:0][W-1:0]   q_px,
  output logic [3:0][W-1:0]   q_py
);

  localparam int NDIV  = (W + DIGIT_W - 1) / DIGIT_W;
  localparam int DW    = NDIV * DIGIT_W;
  localparam int NLANE = 6;

  // Lanes: 0/1 control (2c+1), 2/3 pen (p+1), 4/5 end point (p+1)
  typedef struct packed {
    rec_ctl_t                     ctl;
    logic                         quad;
    logic [3:0][W-1:0]            px;
    logic [3:0][W-1:0]            py;
    logic [NLANE-1:0][DW-1:0]     mag;
    logic [NLANE-1:0]             neg;
    logic [NLANE-1:0][1:0]        rem;
  } stage_t;

  // Sign and magnitude of 2c+1
  function automatic logic [W:0] mag_2c1(input logic [W-1:0] c);
    logic [W:0] v;
    logic [W:0] vn;
    v  = {c, 1'b1};
    vn = ~v + (W+1)'(1);
    return c[W-1] ? {1'b1, vn[W-1:0]} : {1'b0, v[W-1:0]};
  endfunction

  // Sign and magnitude of p+1
  function automatic logic [W:0] mag_p1(input logic [W-1:0] p);
    logic neg;
    neg = p[W-1] & ~(&p);
    return neg ? {1'b1, ~p} : {1'b0, p + W'(1)};
  endfunction

  logic          fig_open_r, fig_open_nxt;
  logic          move_pend_r, move_pend_nxt;
  logic [W-1:0]  pen_x_r, pen_x_nxt;
  logic [W-1:0]  pen_y_r, pen_y_nxt;

  stage_t        s0;
  logic          s0_live;
  logic [W:0]    lane_in [NLANE];
  stage_t        pipe_r [NDIV+1];
  logic [NDIV:0] pv_r;
  stage_t        step [NDIV];
  logic [W-1:0]  sq [NLANE];
  logic          advance, accept;

  // Whole pipeline holds only when a finished item cannot enter the queue
  assign advance  = !(pv_r[NDIV] && q_full);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  // Division lane inputs
  always_comb begin
    lane_in[0] = mag_2c1(in_ctrl1_x);
    lane_in[1] = mag_2c1(in_ctrl1_y);
    lane_in[2] = mag_p1(pen_x_r);
    lane_in[3] = mag_p1(pen_y_r);
    lane_in[4] = mag_p1(in_to_x);
    lane_in[5] = mag_p1(in_to_y);
  end

  // Classify the command and work out the next pen state
  always_comb begin
    fig_open_nxt  = fig_open_r;
    move_pend_nxt = move_pend_r;
    pen_x_nxt     = pen_x_r;
    pen_y_nxt     = pen_y_r;
    s0            = '0;
    s0_live       = 1'b0;
    s0.px[0]      = pen_x_r;
    s0.py[0]      = pen_y_r;
    for (int l = 0; l < NLANE; l++) begin
      s0.neg[l] = lane_in[l][W];
      s0.mag[l] = DW'(lane_in[l][W-1:0]);
    end
    unique case (in_cmd)
      CMD_MOVE: begin
        s0.ctl.has_tag = fig_open_r;
        s0.ctl.tag     = TAG_END;
        s0_live        = fig_open_r;
        fig_open_nxt   = 1'b0;
        move_pend_nxt  = 1'b1;
        pen_x_nxt      = in_to_x;
        pen_y_nxt      = in_to_y;
      end
      CMD_LINE: begin
        // empty contour: line back onto the pending origin is dropped
        if (!(move_pend_r && in_to_x == pen_x_r && in_to_y == pen_y_r)) begin
          s0.ctl.has_begin = move_pend_r;
          s0.ctl.npts      = 2'd1;
          s0.ctl.has_tag   = 1'b1;
          s0.ctl.tag       = TAG_LINE;
          s0.px[1]         = in_to_x;
          s0.py[1]         = in_to_y;
          s0_live          = 1'b1;
          if (move_pend_r) begin
            fig_open_nxt  = 1'b1;
            move_pend_nxt = 1'b0;
          end
          pen_x_nxt = in_to_x;
          pen_y_nxt = in_to_y;
        end
      end
      CMD_QUAD, CMD_CUBIC: begin
        s0.ctl.has_begin = move_pend_r;
        s0.ctl.npts      = 2'd3;
        s0.ctl.has_tag   = 1'b1;
        s0.ctl.tag       = TAG_BEZIER;
        s0.quad          = (in_cmd == CMD_QUAD);
        s0.px[1]         = in_ctrl1_x;
        s0.py[1]         = in_ctrl1_y;
        s0.px[2]         = in_ctrl2_x;
        s0.py[2]         = in_ctrl2_y;
        s0.px[3]         = in_to_x;
        s0.py[3]         = in_to_y;
        s0_live          = 1'b1;
        if (move_pend_r) begin
          fig_open_nxt  = 1'b1;
          move_pend_nxt = 1'b0;
        end
        pen_x_nxt = in_to_x;
        pen_y_nxt = in_to_y;
      end
      CMD_FINISH: begin
        s0.ctl.has_tag = fig_open_r;
        s0.ctl.tag     = TAG_END;
        s0_live        = fig_open_r;
        fig_open_nxt   = 1'b0;
        move_pend_nxt  = 1'b0;
        pen_x_nxt      = '0;
        pen_y_nxt      = '0;
      end
      default: ;
    endcase
  end

  // Pen and figure state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fig_open_r  <= 1'b0;
      move_pend_r <= 1'b0;
      pen_x_r     <= '0;
      pen_y_r     <= '0;
    end else if (accept) begin
      fig_open_r  <= fig_open_nxt;
      move_pend_r <= move_pend_nxt;
      pen_x_r     <= pen_x_nxt;
      pen_y_r     <= pen_y_nxt;
    end
  end

  // Long division by three, one digit per stage, most significant first
  always_comb begin
    div3_digit_t d;
    for (int k = 0; k < NDIV; k++) begin
      step[k] = pipe_r[k];
      for (int l = 0; l < NLANE; l++) begin
        d = div3_digit(pipe_r[k].rem[l],
                       pipe_r[k].mag[l][(NDIV-1-k)*DIGIT_W +: DIGIT_W]);
        step[k].mag[l][(NDIV-1-k)*DIGIT_W +: DIGIT_W] = d.q;
        step[k].rem[l] = d.r;
      end
    end
  end

  // Pipeline registers
  always_ff @(posedge clk) begin
    if (advance) begin
      pipe_r[0] <= s0;
      for (int k = 0; k < NDIV; k++) begin
        pipe_r[k+1] <= step[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (advance) begin
      pv_r <= {pv_r[NDIV-1:0], accept && s0_live};
    end
  end

  // Signed quotients, then the two inner cubic controls
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      sq[l] = pipe_r[NDIV].neg[l] ? -pipe_r[NDIV].mag[l][W-1:0]
                                  :  pipe_r[NDIV].mag[l][W-1:0];
    end
    q_ctl = pipe_r[NDIV].ctl;
    q_px  = pipe_r[NDIV].px;
    q_py  = pipe_r[NDIV].py;
    if (pipe_r[NDIV].quad) begin
      q_px[1] = sq[0] + sq[2];
      q_py[1] = sq[1] + sq[3];
      q_px[2] = sq[0] + sq[4];
      q_py[2] = sq[1] + sq[5];
    end
  end

  assign q_push = pv_r[NDIV] && !q_full;

endmodule

>>> rtl/core/pofs_back.sv
// Record sequencer: walks a queued item's plan and drives the registered result port.
module pofs_back import pofs_pkg::*; #(
  parameter int W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  rec_ctl_t          head_ctl,
  input  logic [3:0][W-1:0] head_px,
  input  logic [3:0][W-1:0] head_py,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_rec_kind,
  output logic [1:0]        out_tag_code,
  output logic [W-1:0]      out_pt_x,
  output logic [W-1:0]      out_pt_y,
  output logic              out_last
);

  logic [2:0]   cnt_r;
  logic         out_valid_r;
  logic         kind_r, last_r;
  logic [1:0]   tag_r;
  logic [W-1:0] x_r, y_r;

  logic [2:0]   total, j;
  logic [1:0]   pidx;
  logic         emit, rec_last;
  logic         kind_c;
  logic [1:0]   tag_c;
  logic [W-1:0] x_c, y_c;

  // Current record of the head item
  always_comb begin
    total    = 3'(head_ctl.has_begin) + 3'(head_ctl.npts) + 3'(head_ctl.has_tag);
    j        = cnt_r - 3'(head_ctl.has_begin);
    pidx     = 2'(j) + 2'd1;
    rec_last = (cnt_r == total - 3'd1);
    kind_c   = REC_TAG;
    tag_c    = head_ctl.tag;
    x_c      = '0;
    y_c      = '0;
    priority if (head_ctl.has_begin && cnt_r == 3'd0) begin
      tag_c = TAG_BEGIN;
      x_c   = head_px[0];
      y_c   = head_py[0];
    end else if (j < 3'(head_ctl.npts)) begin
      kind_c = REC_POINT;
      tag_c  = 2'd0;
      x_c    = head_px[pidx];
      y_c    = head_py[pidx];
    end else begin
      // closing tag of the item
      kind_c = REC_TAG;
    end
  end

  assign emit = head_valid && (!out_valid_r || !out_stall);
  assign pop  = emit && rec_last;

  // Record counter within the head item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (emit) begin
      cnt_r <= rec_last ? 3'd0 : cnt_r + 3'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r <= kind_c;
      tag_r  <= tag_c;
      x_r    <= x_c;
      y_r    <= y_c;
      last_r <= rec_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_rec_kind = kind_r;
  assign out_tag_code = tag_r;
  assign out_pt_x     = x_r;
  assign out_pt_y     = y_r;
  assign out_last     = last_r;

endmodule

>>> rtl/core/path_outline_to_figure_stream_top.sv
// Each item passes the entry register, the division stages, the item queue and the result register.
// Throughput: one command accepted per cycle into the divide pipeline while in_stall is low; the
// result port gives one record per cycle while out_stall is low, and a command makes 0 to 5 records.
// The single result port sets the sustained rate: a curve opening a figure makes 5 records.
// Reset (synchronous, rst_n low) clears pen, figure flags, pipeline valids and queue.
module path_outline_to_figure_stream_top import pofs_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             in_cmd,
  input  logic [COORD_WIDTH-1:0] in_to_x,
  input  logic [COORD_WIDTH-1:0] in_to_y,
  input  logic [COORD_WIDTH-1:0] in_ctrl1_x,
  input  logic [COORD_WIDTH-1:0] in_ctrl1_y,
  input  logic [COORD_WIDTH-1:0] in_ctrl2_x,
  input  logic [COORD_WIDTH-1:0] in_ctrl2_y,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_rec_kind,
  output logic [1:0]             out_tag_code,
  output logic [COORD_WIDTH-1:0] out_pt_x,
  output logic [COORD_WIDTH-1:0] out_pt_y,
  output logic                   out_last
);

  localparam int QW = $bits(rec_ctl_t) + 8 * COORD_WIDTH;

  logic                          q_full, q_push, q_pop, q_nempty;
  rec_ctl_t                      f_ctl, h_ctl;
  logic [3:0][COORD_WIDTH-1:0]   f_px, f_py, h_px, h_py;
  logic [QW-1:0]                 q_wdata, q_rdata;

  // Front end: state, classification, division pipeline
  pofs_front #(.W(COORD_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_to_x    (in_to_x),
    .in_to_y    (in_to_y),
    .in_ctrl1_x (in_ctrl1_x),
    .in_ctrl1_y (in_ctrl1_y),
    .in_ctrl2_x (in_ctrl2_x),
    .in_ctrl2_y (in_ctrl2_y),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_ctl      (f_ctl),
    .q_px       (f_px),
    .q_py       (f_py)
  );

  // Item queue
  assign q_wdata = {f_ctl, f_px, f_py};
  assign {h_ctl, h_px, h_py} = q_rdata;

  pofs_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .nempty (q_nempty)
  );

  // Record sequencer and result register
  pofs_back #(.W(COORD_WIDTH)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (q_nempty),
    .head_ctl     (h_ctl),
    .head_px      (h_px),
    .head_py      (h_py),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rec_kind (out_rec_kind),
    .out_tag_code (out_tag_code),
    .out_pt_x     (out_pt_x),
    .out_pt_y     (out_pt_y),
    .out_last     (out_last)
  );

endmodule

>>> bench/tb_path_outline_to_figure_stream_top.sv
// Self-checking testbench for the path outline to figure stream block.
module tb_path_outline_to_figure_stream_top;
  import pofs_pkg::*;

  localparam int CW          = 32;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 30;
  localparam int MAX_REPORTS = 10;

  localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  // Command codes the block must ignore
  localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

  typedef struct {
    logic [2:0]    cmd;
    logic [CW-1:0] to_x, to_y, c1_x, c1_y, c2_x, c2_y;
  } path_cmd_t;

  typedef struct {
    logic          kind;
    tag_t          tag;
    logic [CW-1:0] x, y;
    logic          rec_last;
  } fig_rec_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [2:0]    in_cmd = '0;
  logic [CW-1:0] in_to_x = '0, in_to_y = '0;
  logic [CW-1:0] in_ctrl1_x = '0, in_ctrl1_y = '0;
  logic [CW-1:0] in_ctrl2_x = '0, in_ctrl2_y = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic          out_rec_kind;
  logic [1:0]    out_tag_code;
  logic [CW-1:0] out_pt_x, out_pt_y;
  logic          out_last;

  path_cmd_t cmd_queue[$];
  fig_rec_t  expected_recs[$];
  fig_rec_t  cmd_recs[$];

  // Outline state as the block should hold it
  logic                 fig_open = 1'b0;
  logic                 move_pend = 1'b0;
  logic signed [CW-1:0] pen_x = '0, pen_y = '0;

  logic cmd_accepted = 1'b0;
  logic hold_off = 1'b0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   cycle_count = 0;
  int   cmds_accepted = 0;
  int   mismatch_count = 0;

  path_outline_to_figure_stream_top #(.COORD_WIDTH(CW)) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_to_x      (in_to_x),
    .in_to_y      (in_to_y),
    .in_ctrl1_x   (in_ctrl1_x),
    .in_ctrl1_y   (in_ctrl1_y),
    .in_ctrl2_x   (in_ctrl2_x),
    .in_ctrl2_y   (in_ctrl2_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rec_kind (out_rec_kind),
    .out_tag_code (out_tag_code),
    .out_pt_x     (out_pt_x),
    .out_pt_y     (out_pt_y),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  // (2c+1)/3, truncated toward zero
  function automatic longint third_twice_plus1(input logic signed [CW-1:0] c);
    longint v;
    v = 2 * longint'(c) + 1;
    return v / 3;
  endfunction

  // (p+1)/3, truncated toward zero
  function automatic longint third_plus1(input logic signed [CW-1:0] p);
    longint v;
    v = longint'(p) + 1;
    return v / 3;
  endfunction

  function automatic fig_rec_t make_rec(input logic kind, input tag_t tag,
                                        input logic [CW-1:0] x, input logic [CW-1:0] y);
    fig_rec_t r;
    r.kind     = kind;
    r.tag      = tag;
    r.x        = x;
    r.y        = y;
    r.rec_last = 1'b0;
    return r;
  endfunction

  // A segment after a move opens the figure at the pen
  function automatic void open_pending_figure();
    if (move_pend) begin
      cmd_recs.push_back(make_rec(REC_TAG, TAG_BEGIN, pen_x, pen_y));
      fig_open  = 1'b1;
      move_pend = 1'b0;
    end
  endfunction

  function automatic void push_point(input logic [CW-1:0] x, input logic [CW-1:0] y);
    cmd_recs.push_back(make_rec(REC_POINT, TAG_BEGIN, x, y));
  endfunction

  // Work out the records one command causes and queue them
  function automatic void predict_records(input path_cmd_t pc);
    logic signed [CW-1:0] tx, ty;
    longint               bx, by;
    tx = pc.to_x;
    ty = pc.to_y;
    cmd_recs.delete();
    case (pc.cmd)
      CMD_MOVE: begin
        if (fig_open) begin
          cmd_recs.push_back(make_rec(REC_TAG, TAG_END, '0, '0));
          fig_open = 1'b0;
        end
        move_pend = 1'b1;
        pen_x     = tx;
        pen_y     = ty;
      end
      CMD_LINE: begin
        // a line back onto a pending origin is an empty contour
        if (!(move_pend && tx == pen_x && ty == pen_y)) begin
          open_pending_figure();
          push_point(tx, ty);
          cmd_recs.push_back(make_rec(REC_TAG, TAG_LINE, '0, '0));
          pen_x = tx;
          pen_y = ty;
        end
      end
      CMD_QUAD: begin
        bx = third_twice_plus1(pc.c1_x);
        by = third_twice_plus1(pc.c1_y);
        open_pending_figure();
        push_point(CW'(bx + third_plus1(pen_x)), CW'(by + third_plus1(pen_y)));
        push_point(CW'(bx + third_plus1(tx)), CW'(by + third_plus1(ty)));
        push_point(tx, ty);
        cmd_recs.push_back(make_rec(REC_TAG, TAG_BEZIER, '0, '0));
        pen_x = tx;
        pen_y = ty;
      end
      CMD_CUBIC: begin
        open_pending_figure();
        push_point(pc.c1_x, pc.c1_y);
        push_point(pc.c2_x, pc.c2_y);
        push_point(tx, ty);
        cmd_recs.push_back(make_rec(REC_TAG, TAG_BEZIER, '0, '0));
        pen_x = tx;
        pen_y = ty;
      end
      CMD_FINISH: begin
        if (fig_open) cmd_recs.push_back(make_rec(REC_TAG, TAG_END, '0, '0));
        fig_open  = 1'b0;
        move_pend = 1'b0;
        pen_x     = '0;
        pen_y     = '0;
      end
      default: ;
    endcase
    if (cmd_recs.size() != 0) cmd_recs[cmd_recs.size()-1].rec_last = 1'b1;
    foreach (cmd_recs[i]) expected_recs.push_back(cmd_recs[i]);
  endfunction

  function automatic void note_mismatch(input string what, input fig_rec_t exp);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("MISMATCH %s: got kind=%0d tag=%0d x=%h y=%h last=%0d",
               what, out_rec_kind, out_tag_code, out_pt_x, out_pt_y, out_last);
      $display("         expected kind=%0d tag=%0d x=%h y=%h last=%0d",
               exp.kind, exp.tag, exp.x, exp.y, exp.rec_last);
    end
  endfunction

  function automatic void check_record();
    fig_rec_t exp;
    if (expected_recs.size() == 0) begin
      note_mismatch("record with nothing expected", make_rec(REC_TAG, TAG_BEGIN, '0, '0));
    end else begin
      exp = expected_recs.pop_front();
      if (out_rec_kind !== exp.kind || out_tag_code !== exp.tag || out_pt_x !== exp.x ||
          out_pt_y !== exp.y || out_last !== exp.rec_last)
        note_mismatch("record fields", exp);
    end
  endfunction

  // Monitor: predict on each accepted command, check each accepted record
  always @(posedge clk) begin
    cycle_count  <= cycle_count + 1;
    cmd_accepted <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      predict_records('{in_cmd, in_to_x, in_to_y, in_ctrl1_x, in_ctrl1_y,
                        in_ctrl2_x, in_ctrl2_y});
      cmds_accepted <= cmds_accepted + 1;
    end
    if (rst_n && out_valid && !out_stall) check_record();
  end

  // Driver: next item goes out once the current one is taken
  always @(negedge clk) begin : driver
    path_cmd_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || cmd_accepted) begin
      if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = cmd_queue.pop_front();
        in_valid   <= 1'b1;
        in_cmd     <= nxt.cmd;
        in_to_x    <= nxt.to_x;
        in_to_y    <= nxt.to_y;
        in_ctrl1_x <= nxt.c1_x;
        in_ctrl1_y <= nxt.c1_y;
        in_ctrl2_x <= nxt.c2_x;
        in_ctrl2_y <= nxt.c2_y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls, random or held off
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // Long hold-off on the result side so the block backs up into its input
  initial begin : pressure
    wait (cmds_accepted >= 40);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  function automatic void add_cmd(input logic [2:0] cmd,
                                  input logic [CW-1:0] tx = '0, input logic [CW-1:0] ty = '0,
                                  input logic [CW-1:0] c1x = '0, input logic [CW-1:0] c1y = '0,
                                  input logic [CW-1:0] c2x = '0, input logic [CW-1:0] c2y = '0);
    cmd_queue.push_back('{cmd, tx, ty, c1x, c1y, c2x, c2y});
  endfunction

  // Coordinates: extremes, values near zero, or anything
  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(5))
          0:       return '0;
          1:       return '1;
          2:       return COORD_MAX;
          3:       return COORD_MIN;
          4:       return CW'(1);
          default: return COORD_MIN + CW'(1);
        endcase
      end
      1, 2:    return CW'($urandom_range(4000)) - CW'(2000);
      default: return CW'($urandom());
    endcase
  endfunction

  function automatic void add_segment(input logic [CW-1:0] mx, input logic [CW-1:0] my);
    case ($urandom_range(3))
      0: add_cmd(CMD_LINE, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord());
      1: add_cmd(CMD_LINE, mx, my, rand_coord(), rand_coord(), rand_coord(), rand_coord());
      2: add_cmd(CMD_QUAD, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord());
      default: add_cmd(CMD_CUBIC, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord());
    endcase
  endfunction

  // Mostly whole figures with random content, some stray commands
  function automatic void gen_random_cmds(input int count);
    int            made;
    logic [2:0]    cmd;
    logic [CW-1:0] mx, my;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 80) begin
        mx = rand_coord();
        my = rand_coord();
        add_cmd(CMD_MOVE, mx, my, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        made++;
        if ($urandom_range(3) == 0) add_cmd(CMD_LINE, mx, my, rand_coord(), rand_coord());
        repeat ($urandom_range(5, 1)) begin
          add_segment(mx, my);
          made++;
        end
        if ($urandom_range(9) < 3) begin
          add_cmd(CMD_FINISH, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord());
          made++;
        end
      end else begin
        cmd = 3'($urandom_range(7));
        add_cmd(cmd, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord());
        if (cmd <= CMD_FINISH) made++;
      end
    end
  endfunction

  task automatic wait_cmds_drained();
    while (cmd_queue.size() != 0 || in_valid) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: segments with no move, empty contour, extremes, spare codes
    add_cmd(CMD_LINE, COORD_MAX, COORD_MIN);
    add_cmd(CMD_QUAD, '1, COORD_MAX, COORD_MIN, COORD_MAX);
    add_cmd(CMD_CUBIC, '0, '0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    add_cmd(CMD_FINISH);
    add_cmd(CMD_MOVE, '0, '0);
    add_cmd(CMD_LINE, '0, '0);
    add_cmd(CMD_LINE, CW'(1), '1);
    add_cmd(CMD_QUAD, '1, COORD_MAX, COORD_MAX, COORD_MIN);
    add_cmd(CMD_QUAD, CW'(-2), CW'(1), '1, CW'(-2));
    add_cmd(CMD_CUBIC, COORD_MIN, COORD_MAX, '1, CW'(2), COORD_MAX, '1);
    add_cmd(CMD_MOVE, COORD_MIN, COORD_MAX);
    add_cmd(CMD_MOVE, CW'(64), CW'(-64));
    add_cmd(CMD_QUAD, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    add_cmd(CMD_LINE, CW'(64), CW'(-64));
    add_cmd(CMD_FINISH, '1, '1, '1, '1, '1, '1);
    add_cmd(CMD_SPARE_LO, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    add_cmd(CMD_SPARE_MID, '1, '1, '1, '1, '1, '1);
    add_cmd(CMD_SPARE_HI, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    add_cmd(CMD_MOVE, CW'(5), CW'(5));
    add_cmd(CMD_FINISH);
    add_cmd(CMD_MOVE, COORD_MAX, COORD_MIN);
    add_cmd(CMD_QUAD, COORD_MIN, COORD_MAX, '1, '1);
    add_cmd(CMD_CUBIC, COORD_MAX, COORD_MAX, '0, '0, COORD_MIN, COORD_MIN);
    add_cmd(CMD_FINISH);

    // No idling, with the long result hold-off inside this stretch
    gen_random_cmds(80);
    wait_cmds_drained();
    idle_pct = 52;
    gen_random_cmds(78);
    wait_cmds_drained();
    idle_pct  = 0;
    stall_pct = 52;
    gen_random_cmds(78);
    wait_cmds_drained();
    idle_pct  = 16;
    stall_pct = 16;
    gen_random_cmds(78);
    wait_cmds_drained();

    while (expected_recs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_recs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
